/* design/lpd_pkg.sv */
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int LEN_W        = 31;
	localparam int SHIFT_W      = 8 * (HEADER_BYTES - 1);
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 32;

	localparam logic [1:0] HDR_LAST = 2'(HEADER_BYTES - 1);

	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = CFG_IDX_W'(1);

	localparam logic [LEN_W-1:0] MIN_LENGTH_RST = LEN_W'(1);
	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(65536);

	typedef struct packed {
		logic [LEN_W-1:0] min_length;
		logic [LEN_W-1:0] max_length;
	} lpd_cfg_t;

endpackage

/* design/lpd_if.sv */
// ----------------------------------------------------------------------------
// lpd_if
// Valid/ready channels of the deframer: received bytes, results, config.
// ----------------------------------------------------------------------------
interface lpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       end_of_message;
	logic       length_error;

	modport source (output valid, output payload_byte, output end_of_message,
		output length_error, input ready);
	modport sink   (input valid, input payload_byte, input end_of_message,
		input length_error, output ready);
endinterface

interface lpd_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/lpd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lpd_cfg_regs
// Length limit registers, written through the config channel.
// ----------------------------------------------------------------------------
module lpd_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	lpd_cfg_if.sink         cfg,
	output lpd_pkg::lpd_cfg_t limits
);
	import lpd_pkg::*;

	logic [LEN_W-1:0] min_length_q;
	logic [LEN_W-1:0] max_length_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RST;
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg.valid) begin
			// unknown indexes are dropped
			if (cfg.index == REG_MIN_LENGTH) begin
				min_length_q <= cfg.data[LEN_W-1:0];
			end
			if (cfg.index == REG_MAX_LENGTH) begin
				max_length_q <= cfg.data[LEN_W-1:0];
			end
		end
	end

	assign limits.min_length = min_length_q;
	assign limits.max_length = max_length_q;

endmodule

/* design/lpd_core.sv */
// ----------------------------------------------------------------------------
// lpd_core
// Input register, header/payload sequencing and result register.
// ----------------------------------------------------------------------------
module lpd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  lpd_pkg::lpd_cfg_t limits,
	lpd_in_if.sink            rx,
	lpd_out_if.source         tx
);
	import lpd_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR   = 2'd2
	} phase_t;

	logic             valid_s1;
	logic [7:0]       byte_s1;

	phase_t           phase_q, phase_d;
	logic [1:0]       hdr_cnt_q, hdr_cnt_d;
	logic [SHIFT_W-1:0] hdr_shift_q, hdr_shift_d;
	logic [LEN_W-1:0] left_q, left_d;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_eom_q;
	logic             out_err_q;

	logic             out_free;
	logic             step;
	logic             res_valid;
	logic [7:0]       res_byte;
	logic             res_eom;
	logic             res_err;
	logic [31:0]      len;
	logic             len_bad;

	assign out_free = !out_valid_q || tx.ready;
	assign step     = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign len     = {byte_s1, hdr_shift_q};
	// bit 31 set means negative, below any minimum
	assign len_bad = len[31] || (len[LEN_W-1:0] < limits.min_length) ||
		(len[LEN_W-1:0] > limits.max_length);

	always_comb begin
		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		hdr_shift_d = hdr_shift_q;
		left_d      = left_q;
		res_valid   = 1'b0;
		res_byte    = 8'd0;
		res_eom     = 1'b0;
		res_err     = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_cnt_q != HDR_LAST) begin
					hdr_shift_d[8*hdr_cnt_q +: 8] = byte_s1;
					hdr_cnt_d = hdr_cnt_q + 2'd1;
				end else begin
					hdr_shift_d = '0;
					hdr_cnt_d   = 2'd0;
					if (len_bad) begin
						phase_d   = PH_ERROR;
						res_valid = 1'b1;
						res_err   = 1'b1;
					end else if (len == 32'd0) begin
						phase_d = PH_HEADER;
					end else begin
						left_d  = len[LEN_W-1:0];
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				left_d    = left_q - LEN_W'(1);
				res_valid = 1'b1;
				res_byte  = byte_s1;
				res_eom   = (left_q == LEN_W'(1));
				if (res_eom) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				// error: drop everything until reset
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= 2'd0;
			hdr_shift_q <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q     <= phase_d;
				hdr_cnt_q   <= hdr_cnt_d;
				hdr_shift_q <= hdr_shift_d;
				left_q      <= left_d;
			end
			if (out_free) begin
				out_valid_q <= step && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_byte_q <= res_byte;
			out_eom_q  <= res_eom;
			out_err_q  <= res_err;
		end
	end

	assign tx.valid          = out_valid_q;
	assign tx.payload_byte   = out_byte_q;
	assign tx.end_of_message = out_eom_q;
	assign tx.length_error   = out_err_q;

endmodule

/* design/length_prefix_deframer.sv */
// Path: an accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the input register and the result
//   register both advance whenever the result register is empty or taken.
// Reset: arst_n clears to header phase with limits min 1, max 65536;
//   after a length error the block drops all bytes until reset.
// ----------------------------------------------------------------------------
// length_prefix_deframer
// Splits a byte stream into messages framed by a 4-byte signed LE length.
// ----------------------------------------------------------------------------
module length_prefix_deframer (
	input  logic      clk,
	input  logic      arst_n,
	lpd_in_if.sink    rx,
	lpd_out_if.source tx,
	lpd_cfg_if.sink   cfg
);
	import lpd_pkg::*;

	lpd_cfg_t limits;

	lpd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.limits (limits)
	);

	lpd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.limits (limits),
		.rx     (rx),
		.tx     (tx)
	);

endmodule
